>>> hw/rtl/pfre_pkg.sv
// Package for the page framebuffer region engine.
// Holds the command and result item types, the decoded operation passed from
// the front end to the back end, and the default screen geometry.
package pfre_pkg;

   localparam int SCREEN_WIDTH_DEF  = 128;
   localparam int SCREEN_HEIGHT_DEF = 64;
   localparam int OPQ_DEPTH         = 2;
   localparam int RSPQ_DEPTH        = 2;

   localparam logic [2:0] KIND_SET_PIXEL  = 3'd0;
   localparam logic [2:0] KIND_INVERT     = 3'd1;
   localparam logic [2:0] KIND_CLEAR_ALL  = 3'd2;
   localparam logic [2:0] KIND_WRITE_BYTE = 3'd3;
   localparam logic [2:0] KIND_READ_BYTE  = 3'd4;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] col_x;
      logic [7:0] row_y;
      logic [7:0] span_x;
      logic [7:0] span_y;
      logic [2:0] page_sel;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       out_of_range;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_PIXEL,
      OP_INVERT,
      OP_CLEAR,
      OP_WRITE,
      OP_READ
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic        oor;
      logic [2:0]  page_first;
      logic [2:0]  page_last;
      logic [7:0]  col_first;
      logic [7:0]  col_last;
      logic [2:0]  row_lo;
      logic [2:0]  row_hi;
      logic [7:0]  data;
   } op_type;

endpackage

>>> hw/rtl/page_framebuffer_region_engine.sv
// Top level of the page framebuffer region engine.
// Joins the front end, the operation queue, the back end and the result
// queue. Uses pfre_pkg, pfre_front, pfre_queue and pfre_back.
//
// Commands enter through a queue-like port: an item is taken on a rising
// edge with req_push high and req_full low. Results leave the same way: the
// oldest result sits on rsp_data while rsp_empty is low and is taken on a
// rising edge with rsp_pop high. Every command gives exactly one result.
// Set pixel, write byte, read byte, out-of-range and empty commands each pass
// once through the back end, which issues one only while the result queue
// has room counting the result still in flight, so even with a receiver that
// takes every result at once it waits while two results are queued or in
// flight; a result passes the read-modify-write stage and is then registered
// in the result queue. An invert takes a setup step and then visits each
// covered byte in turn, and a clear takes a setup step and then writes each
// store byte in turn. After reset the store is swept to zero, one byte per
// cycle over pages times SCREEN_WIDTH bytes, and req_full stays high
// meanwhile. When the receiver stalls, results collect in a two-item queue,
// the back end then halts, the operation queue fills and req_full rises;
// nothing is dropped.
module page_framebuffer_region_engine #(
   parameter int SCREEN_WIDTH  = pfre_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = pfre_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  pfre_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output pfre_pkg::rsp_type rsp_data
);
   import pfre_pkg::*;

   localparam int RCW = $clog2(RSPQ_DEPTH + 1);

   logic             op_full, op_push, op_empty, op_pop, init_busy, rsp_push;
   op_type           op_in, op_head;
   rsp_type          rsp_item;
   logic [RCW-1:0]   rsp_count;

   pfre_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_front (
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .q_full    (op_full),
      .init_busy (init_busy),
      .q_push    (op_push),
      .q_data    (op_in)
   );

   pfre_queue #(
      .item_type (op_type),
      .DEPTH     (OPQ_DEPTH)
   ) u_op_queue (
      .clock (clock),
      .reset (reset),
      .push  (op_push),
      .full  (op_full),
      .wdata (op_in),
      .pop   (op_pop),
      .empty (op_empty),
      .rdata (op_head),
      .count ()
   );

   pfre_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .RSP_DEPTH     (RSPQ_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_empty  (op_empty),
      .op_data   (op_head),
      .op_pop    (op_pop),
      .rsp_count (rsp_count),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_item),
      .init_busy (init_busy)
   );

   pfre_queue #(
      .item_type (rsp_type),
      .DEPTH     (RSPQ_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .full  (),
      .wdata (rsp_item),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .rdata (rsp_data),
      .count (rsp_count)
   );

endmodule

>>> hw/rtl/pfre_queue.sv
// Small first-in first-out queue used between the engine's parts.
// Generic in its item type and depth; depends on no package.
module pfre_queue #(
   parameter type item_type = logic [7:0],
   parameter int  DEPTH     = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  item_type                       wdata,
   input  logic                           pop,
   output logic                           empty,
   output item_type                       rdata,
   output logic [$clog2(DEPTH+1)-1:0]     count
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        store_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            push_ok, pop_ok;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rdata   = store_ff[rd_ptr_ff];
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push_ok, pop_ok})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         store_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hw/rtl/pfre_front.sv
// Front end of the engine: accepts command items, checks bounds and clips
// rectangles, and turns each item into a decoded operation. Uses pfre_pkg.
module pfre_front #(
   parameter int SCREEN_WIDTH  = pfre_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = pfre_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic              req_push,
   output logic              req_full,
   input  pfre_pkg::req_type req_data,
   input  logic              q_full,
   input  logic              init_busy,
   output logic              q_push,
   output pfre_pkg::op_type  q_data
);
   import pfre_pkg::*;

   localparam int         NPAGES     = (SCREEN_HEIGHT + 7) / 8;
   localparam logic [8:0] WIDTH_LIM  = 9'(SCREEN_WIDTH);
   localparam logic [8:0] HEIGHT_LIM = 9'(SCREEN_HEIGHT);
   localparam logic [3:0] PAGE_LIM   = 4'(NPAGES);

   logic [8:0] x_end, y_end, x_clip, y_clip, x_last, y_last;
   logic       rect_empty, pix_ok, byte_ok;
   logic [7:0] pix_mask;

   assign x_end  = {1'b0, req_data.col_x} + {1'b0, req_data.span_x};
   assign y_end  = {1'b0, req_data.row_y} + {1'b0, req_data.span_y};
   assign x_clip = (x_end > WIDTH_LIM) ? WIDTH_LIM : x_end;
   assign y_clip = (y_end > HEIGHT_LIM) ? HEIGHT_LIM : y_end;
   assign x_last = x_clip - 9'd1;
   assign y_last = y_clip - 9'd1;

   assign rect_empty = (req_data.span_x == '0) || (req_data.span_y == '0) ||
                       ({1'b0, req_data.col_x} >= x_clip) ||
                       ({1'b0, req_data.row_y} >= y_clip);
   assign pix_ok  = ({1'b0, req_data.col_x} < WIDTH_LIM) &&
                    ({1'b0, req_data.row_y} < HEIGHT_LIM);
   assign byte_ok = ({1'b0, req_data.col_x} < WIDTH_LIM) &&
                    ({1'b0, req_data.page_sel} < PAGE_LIM);
   assign pix_mask = 8'd1 << req_data.row_y[2:0];

   assign req_full = q_full || init_busy;
   assign q_push   = req_push && !req_full;

   always_comb begin
      q_data      = '0;
      q_data.kind = OP_NOP;
      unique case (req_data.kind)
         KIND_SET_PIXEL: begin
            if (pix_ok) begin
               q_data.kind       = OP_PIXEL;
               q_data.page_first = req_data.row_y[5:3];
               q_data.col_first  = req_data.col_x;
               q_data.data       = pix_mask;
            end else begin
               q_data.oor = 1'b1;
            end
         end
         KIND_INVERT: begin
            if (!rect_empty) begin
               q_data.kind       = OP_INVERT;
               q_data.page_first = req_data.row_y[5:3];
               q_data.page_last  = y_last[5:3];
               q_data.col_first  = req_data.col_x;
               q_data.col_last   = x_last[7:0];
               q_data.row_lo     = req_data.row_y[2:0];
               q_data.row_hi     = y_last[2:0];
            end
         end
         KIND_CLEAR_ALL: begin
            q_data.kind = OP_CLEAR;
         end
         KIND_WRITE_BYTE: begin
            if (byte_ok) begin
               q_data.kind       = OP_WRITE;
               q_data.page_first = req_data.page_sel;
               q_data.col_first  = req_data.col_x;
               q_data.data       = req_data.data_byte;
            end else begin
               q_data.oor = 1'b1;
            end
         end
         KIND_READ_BYTE: begin
            if (byte_ok) begin
               q_data.kind       = OP_READ;
               q_data.page_first = req_data.page_sel;
               q_data.col_first  = req_data.col_x;
            end else begin
               q_data.oor = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

>>> hw/rtl/pfre_back.sv
// Back end of the engine: sequences decoded operations over the frame store
// with a read stage and a read-modify-write stage. Uses pfre_pkg.
module pfre_back #(
   parameter int SCREEN_WIDTH  = pfre_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = pfre_pkg::SCREEN_HEIGHT_DEF,
   parameter int RSP_DEPTH     = pfre_pkg::RSPQ_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             op_empty,
   input  pfre_pkg::op_type                 op_data,
   output logic                             op_pop,
   input  logic [$clog2(RSP_DEPTH+1)-1:0]   rsp_count,
   output logic                             rsp_push,
   output pfre_pkg::rsp_type                rsp_data,
   output logic                             init_busy
);
   import pfre_pkg::*;

   localparam int NPAGES      = (SCREEN_HEIGHT + 7) / 8;
   localparam int STORE_BYTES = NPAGES * SCREEN_WIDTH;
   localparam int AW          = $clog2(STORE_BYTES);
   localparam int RCW         = $clog2(RSP_DEPTH + 1);

   typedef enum logic [1:0] {ST_CLEAR, ST_RUN, ST_INVERT} state_type;
   typedef enum logic [2:0] {ACC_NONE, ACC_OR, ACC_XOR, ACC_STORE, ACC_READ} acc_type;

   state_type       state_ff, state_in;
   logic [2:0]      page_ff, page_in;
   logic [7:0]      col_ff, col_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic            resp_ff, resp_in;
   op_type          cur_ff, cur_in;

   logic            s1_valid, s1_last, s1_oor, s1_use_clr;
   acc_type         s1_acc;
   logic [7:0]      s1_data, s1_col;
   logic [2:0]      s1_page;
   logic [AW-1:0]   s1_addr;
   logic            room, clr_last, inv_last;
   logic [RCW:0]    rsp_used;
   logic [2:0]      mask_lo, mask_hi;
   logic [7:0]      inv_mask;

   logic            s2_valid_ff, s2_last_ff, s2_oor_ff;
   acc_type         s2_acc_ff;
   logic [7:0]      s2_data_ff;
   logic [AW-1:0]   s2_addr_ff;
   logic            fwd_ff;
   logic [7:0]      fwd_data_ff, mem_q_ff;
   logic [7:0]      eff_rd, wdata;
   logic            wr_en;
   logic [7:0]      frame_mem [STORE_BYTES];

   assign rsp_used  = {1'b0, rsp_count} + {{RCW{1'b0}}, s2_valid_ff && s2_last_ff};
   assign room      = (rsp_used < (RCW + 1)'(RSP_DEPTH));
   assign clr_last  = (clr_ff == AW'(STORE_BYTES - 1));
   assign inv_last  = (page_ff == cur_ff.page_last) && (col_ff == cur_ff.col_last);
   assign init_busy = (state_ff == ST_CLEAR) && !resp_ff;

   assign mask_lo = (page_ff == cur_ff.page_first) ? cur_ff.row_lo : 3'd0;
   assign mask_hi = (page_ff == cur_ff.page_last) ? cur_ff.row_hi : 3'd7;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         inv_mask[i] = (3'(i) >= mask_lo) && (3'(i) <= mask_hi);
      end
   end

   always_comb begin
      state_in   = state_ff;
      page_in    = page_ff;
      col_in     = col_ff;
      clr_in     = clr_ff;
      resp_in    = resp_ff;
      cur_in     = cur_ff;
      op_pop     = 1'b0;
      s1_valid   = 1'b0;
      s1_acc     = ACC_NONE;
      s1_data    = '0;
      s1_last    = 1'b0;
      s1_oor     = 1'b0;
      s1_use_clr = 1'b0;
      s1_page    = op_data.page_first;
      s1_col     = op_data.col_first;
      unique case (state_ff)
         ST_CLEAR: begin
            if (!(clr_last && resp_ff) || room) begin
               s1_valid   = 1'b1;
               s1_acc     = ACC_STORE;
               s1_last    = clr_last && resp_ff;
               s1_use_clr = 1'b1;
               if (clr_last) begin
                  state_in = ST_RUN;
               end else begin
                  clr_in = clr_ff + 1'b1;
               end
            end
         end
         ST_RUN: begin
            if (!op_empty) begin
               unique case (op_data.kind)
                  OP_INVERT: begin
                     op_pop   = 1'b1;
                     cur_in   = op_data;
                     page_in  = op_data.page_first;
                     col_in   = op_data.col_first;
                     state_in = ST_INVERT;
                  end
                  OP_CLEAR: begin
                     op_pop   = 1'b1;
                     clr_in   = '0;
                     resp_in  = 1'b1;
                     state_in = ST_CLEAR;
                  end
                  OP_NOP, OP_PIXEL, OP_WRITE, OP_READ: begin
                     if (room) begin
                        op_pop   = 1'b1;
                        s1_valid = 1'b1;
                        s1_last  = 1'b1;
                        s1_oor   = op_data.oor;
                        s1_data  = op_data.data;
                        unique case (op_data.kind)
                           OP_PIXEL: s1_acc = ACC_OR;
                           OP_WRITE: s1_acc = ACC_STORE;
                           OP_READ:  s1_acc = ACC_READ;
                           default:  s1_acc = ACC_NONE;
                        endcase
                     end
                  end
                  default: begin
                     op_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_INVERT: begin
            if (!inv_last || room) begin
               s1_valid = 1'b1;
               s1_acc   = ACC_XOR;
               s1_data  = inv_mask;
               s1_last  = inv_last;
               s1_page  = page_ff;
               s1_col   = col_ff;
               if (inv_last) begin
                  state_in = ST_RUN;
               end else if (col_ff == cur_ff.col_last) begin
                  col_in  = cur_ff.col_first;
                  page_in = page_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   assign s1_addr = s1_use_clr ? clr_ff :
                    AW'(32'(s1_page) * 32'(SCREEN_WIDTH) + 32'(s1_col));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         resp_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         resp_ff  <= resp_in;
      end
      page_ff <= page_in;
      col_ff  <= col_in;
      cur_ff  <= cur_in;
   end

   assign eff_rd = fwd_ff ? fwd_data_ff : mem_q_ff;
   assign wr_en  = s2_valid_ff &&
                   ((s2_acc_ff == ACC_OR) || (s2_acc_ff == ACC_XOR) ||
                    (s2_acc_ff == ACC_STORE));

   always_comb begin
      unique case (s2_acc_ff)
         ACC_OR:    wdata = eff_rd | s2_data_ff;
         ACC_XOR:   wdata = eff_rd ^ s2_data_ff;
         ACC_STORE: wdata = s2_data_ff;
         default:   wdata = eff_rd;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid;
         fwd_ff      <= s1_valid && wr_en && (s1_addr == s2_addr_ff);
      end
      s2_addr_ff  <= s1_addr;
      s2_acc_ff   <= s1_acc;
      s2_data_ff  <= s1_data;
      s2_last_ff  <= s1_last;
      s2_oor_ff   <= s1_oor;
      fwd_data_ff <= wdata;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[s2_addr_ff] <= wdata;
      end
      mem_q_ff <= frame_mem[s1_addr];
   end

   assign rsp_push               = s2_valid_ff && s2_last_ff;
   assign rsp_data.read_byte    = (s2_acc_ff == ACC_READ) ? eff_rd : '0;
   assign rsp_data.out_of_range = s2_oor_ff;

   a_rsp_space: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (rsp_count < RCW'(RSP_DEPTH)))
      else $error("Result pushed into a full result queue.");

   a_inv_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INVERT) |-> ((page_ff <= cur_ff.page_last) &&
         (col_ff >= cur_ff.col_first) && (col_ff <= cur_ff.col_last)))
      else $error("Invert walk left its clipped rectangle.");

   a_fwd_src: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> $past(wr_en))
      else $error("Forwarded byte without a write in the previous cycle.");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      op_pop |-> (!op_empty && !init_busy))
      else $error("Operation taken from an empty queue or during clearing.");

endmodule
